// ===== rtl/core/pwmsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwmsc_pkg
// Shared widths, defaults, cell control bundle and saturating add for the
// position weight matrix window scorer.
// ----------------------------------------------------------------------------
package pwmsc_pkg;

    localparam int SCORE_W       = 21;
    localparam int WEIGHT_W      = 16;
    localparam int SYMBOL_W      = 2;
    localparam int POSITION_W    = 5;
    localparam int LEN_W         = 6;

    localparam int MAX_MOTIF_DEF = 32;
    localparam int ALPHABET_DEF  = 4;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

    // Input item kinds.
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Control and data broadcast from the top level to every cell.
    typedef struct packed {
        logic                       shift;
        logic                       wr_en;
        logic [SYMBOL_W-1:0]        symbol;
        logic [POSITION_W-1:0]      position;
        logic signed [WEIGHT_W-1:0] weight;
    } t_cell_ctrl;

    // Add a weight to a partial sum, clamp to the score range.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0]  a,
        input logic signed [WEIGHT_W-1:0] w
    );
        logic signed [SCORE_W:0] s;
        s = (SCORE_W+1)'(a) + (SCORE_W+1)'(w);
        if (s > (SCORE_W+1)'(SCORE_MAX)) begin
            sat_add = SCORE_MAX;
        end else if (s < (SCORE_W+1)'(SCORE_MIN)) begin
            sat_add = SCORE_MIN;
        end else begin
            sat_add = s[SCORE_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pwmsc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwmsc_cell
// One motif position: holds its weight row and one partial sum, adds the
// weight of the incoming symbol and hands the sum to the next cell.
// ----------------------------------------------------------------------------
module pwmsc_cell #(
    parameter int CELL_IDX = 0,
    parameter int ALPHABET = pwmsc_pkg::ALPHABET_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire pwmsc_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic signed [pwmsc_pkg::SCORE_W-1:0] i_sum,
    output logic signed [pwmsc_pkg::SCORE_W-1:0]     o_sum
);

    localparam int IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    logic signed [pwmsc_pkg::WEIGHT_W-1:0] r_weight [ALPHABET];
    logic signed [pwmsc_pkg::SCORE_W-1:0]  r_sum;

    logic [IDX_W-1:0]                      sym_idx;
    logic                                  sym_ok;
    logic                                  wr_hit;
    logic signed [pwmsc_pkg::WEIGHT_W-1:0] w_sel;

    assign sym_idx = IDX_W'(i_ctrl.symbol);
    assign sym_ok  = (32'(i_ctrl.symbol) < ALPHABET);
    assign wr_hit  = i_ctrl.wr_en && sym_ok && (32'(i_ctrl.position) == CELL_IDX);

    // Out-of-alphabet symbols contribute nothing.
    assign w_sel = sym_ok ? r_weight[sym_idx] : '0;
    assign o_sum = pwmsc_pkg::sat_add(r_sum, w_sel);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_weight[sym_idx] <= i_ctrl.weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.shift) begin
            r_sum <= i_sum;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pwm_sliding_window_scorer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_sliding_window_scorer
// Output: a result beat is registered and appears on the outputs in the cycle after its symbol.
// Throughput: one item per cycle while the input is not stalled; the cell chain advances on every symbol.
// Stall: the input stalls only while a result is held and the output stalls.
// Reset (synchronous, active low): motif length 32, window filling restarted,
// partial sums cleared, no result pending; weight table undefined until written.
// ----------------------------------------------------------------------------
module pwm_sliding_window_scorer #(
    parameter int MAX_MOTIF = pwmsc_pkg::MAX_MOTIF_DEF,
    parameter int ALPHABET  = pwmsc_pkg::ALPHABET_DEF
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,

    input  wire                                          i_cfg_we,
    input  wire [pwmsc_pkg::LEN_W-1:0]                   i_cfg_wdata,

    input  wire                                          i_in_valid,
    output logic                                         o_in_stall,
    input  wire                                          i_kind,
    input  wire [pwmsc_pkg::SYMBOL_W-1:0]                i_symbol,
    input  wire [pwmsc_pkg::POSITION_W-1:0]              i_position,
    input  wire logic signed [pwmsc_pkg::WEIGHT_W-1:0]   i_weight,
    input  wire                                          i_first,
    input  wire                                          i_last,

    output logic                                         o_out_valid,
    input  wire                                          i_out_stall,
    output logic signed [pwmsc_pkg::SCORE_W-1:0]         o_window_score,
    output logic                                         o_end_of_sequence,
    output logic                                         o_too_short
);

    localparam int LW = $clog2(MAX_MOTIF + 1);

    logic [pwmsc_pkg::LEN_W-1:0] r_motif_length;
    logic [LW-1:0]               r_fill;
    logic                        r_valid;
    logic signed [pwmsc_pkg::SCORE_W-1:0] r_score;
    logic                        r_eos;
    logic                        r_short;

    logic [LW-1:0]               n_fill;
    logic                        n_emit;
    logic                        n_short;

    logic                        accept;
    logic [LW-1:0]               win_len;
    logic [LW-1:0]               fill_base;
    logic [LW-1:0]               fill_inc;

    pwmsc_pkg::t_cell_ctrl       ctrl;
    logic signed [pwmsc_pkg::SCORE_W-1:0] chain_sum [MAX_MOTIF+1];

    assign o_in_stall = r_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Clamp the programmed length into 1..MAX_MOTIF.
    always_comb begin
        if (r_motif_length == '0) begin
            win_len = LW'(1);
        end else if (32'(r_motif_length) > MAX_MOTIF) begin
            win_len = LW'(MAX_MOTIF);
        end else begin
            win_len = LW'(r_motif_length);
        end
    end

    assign ctrl.shift    = accept && (i_kind == pwmsc_pkg::KIND_SYMBOL);
    assign ctrl.wr_en    = accept && (i_kind == pwmsc_pkg::KIND_WEIGHT);
    assign ctrl.symbol   = i_symbol;
    assign ctrl.position = i_position;
    assign ctrl.weight   = i_weight;

    // Newest window always starts from zero at the head of the chain.
    assign chain_sum[0] = '0;

    for (genvar g = 0; g < MAX_MOTIF; g++) begin : g_cell
        pwmsc_cell #(
            .CELL_IDX (g),
            .ALPHABET (ALPHABET)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_sum   (chain_sum[g]),
            .o_sum   (chain_sum[g+1])
        );
    end

    // Fill tracking and result decision for a symbol beat.
    always_comb begin
        fill_base = i_first ? '0 : r_fill;
        fill_inc  = (fill_base < win_len) ? fill_base + LW'(1) : fill_base;
        n_emit    = 1'b0;
        n_short   = 1'b0;
        n_fill    = fill_inc;
        if (fill_inc >= win_len) begin
            n_emit = 1'b1;
            if (i_last) begin
                n_fill = '0;
            end
        end else if (i_last) begin
            n_emit  = 1'b1;
            n_short = 1'b1;
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_length <= pwmsc_pkg::LEN_RESET;
            r_fill         <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_motif_length <= i_cfg_wdata;
                r_fill         <= '0;
            end else if (ctrl.shift) begin
                r_fill <= n_fill;
            end
            if (ctrl.shift && n_emit) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.shift && n_emit) begin
            r_score <= n_short ? '0 : chain_sum[win_len];
            r_eos   <= i_last;
            r_short <= n_short;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_window_score    = r_score;
    assign o_end_of_sequence = r_eos;
    assign o_too_short       = r_short;

endmodule
`default_nettype wire

// ===== test/tb_pwm_sliding_window_scorer.sv =====
// ----------------------------------------------------------------------------
// tb_pwm_sliding_window_scorer
// Drives weight table writes and symbol sequences into the window scorer under
// several motif lengths. A scan model in the bench predicts every score beat,
// and each output beat is compared field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_pwm_sliding_window_scorer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = pwmsc_pkg::MAX_MOTIF_DEF * pwmsc_pkg::ALPHABET_DEF;

    typedef struct {
        logic signed [pwmsc_pkg::SCORE_W-1:0] score;
        logic                                 eos;
        logic                                 short_seq;
    } t_score_beat;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [pwmsc_pkg::LEN_W-1:0]           cfg_wdata = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic                                  kind = pwmsc_pkg::KIND_SYMBOL;
    logic [pwmsc_pkg::SYMBOL_W-1:0]        symbol = '0;
    logic [pwmsc_pkg::POSITION_W-1:0]      position = '0;
    logic signed [pwmsc_pkg::WEIGHT_W-1:0] weight = '0;
    logic                                  first = 1'b0;
    logic                                  last = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [pwmsc_pkg::SCORE_W-1:0]  window_score;
    logic                                  end_of_sequence;
    logic                                  too_short;

    // scan model state
    logic signed [pwmsc_pkg::WEIGHT_W-1:0] weight_tbl [TBL_DEPTH];
    logic signed [pwmsc_pkg::SCORE_W-1:0]  running_sum [pwmsc_pkg::MAX_MOTIF_DEF];
    int                                    fill_cnt = 0;
    logic [pwmsc_pkg::LEN_W-1:0]           motif_len = pwmsc_pkg::LEN_RESET;

    t_score_beat                score_q [$];
    t_score_beat                head;
    int                         errors = 0;
    bit                         calm = 1'b0;

    pwm_sliding_window_scorer u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (kind),
        .i_symbol          (symbol),
        .i_position        (position),
        .i_weight          (weight),
        .i_first           (first),
        .i_last            (last),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_window_score    (window_score),
        .o_end_of_sequence (end_of_sequence),
        .o_too_short       (too_short)
    );

    always #4 clk = ~clk;

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int window_len();
        if (motif_len == 0) begin
            return 1;
        end
        if (motif_len > pwmsc_pkg::MAX_MOTIF_DEF) begin
            return pwmsc_pkg::MAX_MOTIF_DEF;
        end
        return int'(motif_len);
    endfunction

    function automatic logic signed [pwmsc_pkg::SCORE_W-1:0] clamp_add(
        input logic signed [pwmsc_pkg::SCORE_W-1:0]  a,
        input logic signed [pwmsc_pkg::WEIGHT_W-1:0] w
    );
        int s;
        s = int'(a) + int'(w);
        if (s > int'(pwmsc_pkg::SCORE_MAX)) begin
            return pwmsc_pkg::SCORE_MAX;
        end
        if (s < int'(pwmsc_pkg::SCORE_MIN)) begin
            return pwmsc_pkg::SCORE_MIN;
        end
        return pwmsc_pkg::SCORE_W'(s);
    endfunction

    // Advance every filling window by one symbol and queue the beat it causes.
    task automatic score_window(input logic [pwmsc_pkg::SYMBOL_W-1:0] sym, input logic f,
                                input logic l);
        int          len;
        t_score_beat beat;
        len = window_len();
        if (f) begin
            fill_cnt = 0;
        end
        beat.score = clamp_add(running_sum[len-1],
                               weight_tbl[(len-1)*pwmsc_pkg::ALPHABET_DEF + sym]);
        for (int d = len - 1; d >= 1; d--) begin
            running_sum[d] = clamp_add(running_sum[d-1],
                                       weight_tbl[(d-1)*pwmsc_pkg::ALPHABET_DEF + sym]);
        end
        running_sum[0] = '0;
        if (fill_cnt < len) begin
            fill_cnt++;
        end
        if (fill_cnt >= len) begin
            beat.eos       = l;
            beat.short_seq = 1'b0;
            score_q.push_back(beat);
            if (l) begin
                fill_cnt = 0;
            end
        end else if (l) begin
            beat.score     = '0;
            beat.eos       = 1'b1;
            beat.short_seq = 1'b1;
            score_q.push_back(beat);
            fill_cnt = 0;
        end
    endtask

    task automatic send_beat(input logic k, input logic [pwmsc_pkg::SYMBOL_W-1:0] sym,
                             input logic [pwmsc_pkg::POSITION_W-1:0] pos,
                             input logic signed [pwmsc_pkg::WEIGHT_W-1:0] w,
                             input logic f, input logic l);
        if (!calm && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        symbol   <= sym;
        position <= pos;
        weight   <= w;
        first    <= f;
        last     <= l;
        do @(posedge clk); while (in_stall);
        if (k == pwmsc_pkg::KIND_WEIGHT) begin
            weight_tbl[pos*pwmsc_pkg::ALPHABET_DEF + sym] = w;
        end else begin
            score_window(sym, f, l);
        end
    endtask

    task automatic send_symbol(input logic [pwmsc_pkg::SYMBOL_W-1:0] sym, input logic f,
                               input logic l);
        send_beat(pwmsc_pkg::KIND_SYMBOL, sym, pwmsc_pkg::POSITION_W'($urandom),
                  pwmsc_pkg::WEIGHT_W'($urandom), f, l);
    endtask

    // Drain all pending beats, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_motif_length(input logic [pwmsc_pkg::LEN_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        motif_len = v;
        fill_cnt  = 0;
    endtask

    // Fill every table entry; symbol 0 and 3 get the weight extremes.
    task automatic test_table_load();
        logic signed [pwmsc_pkg::WEIGHT_W-1:0] w;
        for (int p = 0; p < pwmsc_pkg::MAX_MOTIF_DEF; p++) begin
            for (int s = 0; s < pwmsc_pkg::ALPHABET_DEF; s++) begin
                if (s == 0) begin
                    w = 16'sh8000;
                end else if (s == pwmsc_pkg::ALPHABET_DEF - 1) begin
                    w = 16'sh7fff;
                end else begin
                    w = pwmsc_pkg::WEIGHT_W'($urandom);
                end
                send_beat(pwmsc_pkg::KIND_WEIGHT, pwmsc_pkg::SYMBOL_W'(s),
                          pwmsc_pkg::POSITION_W'(p), w, 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_sequence_cases();
        write_motif_length(pwmsc_pkg::LEN_W'(3));
        // flags on a table write carry no meaning
        send_beat(pwmsc_pkg::KIND_WEIGHT, 2'd3, 5'd31, 16'sh7fff, 1'b1, 1'b1);
        send_beat(pwmsc_pkg::KIND_WEIGHT, 2'd0, 5'd0, 16'sh8000, 1'b1, 1'b1);
        // full window then one more
        send_symbol(2'd0, 1'b1, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b0);
        send_symbol(2'd2, 1'b0, 1'b0);
        send_symbol(2'd3, 1'b0, 1'b1);
        // too short: single symbol, then two symbols
        send_symbol(2'd2, 1'b1, 1'b1);
        send_symbol(2'd1, 1'b1, 1'b0);
        send_symbol(2'd3, 1'b0, 1'b1);
        // new sequence after last without first
        send_symbol(2'd3, 1'b0, 1'b0);
        send_symbol(2'd0, 1'b0, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b1);
        // first in the middle restarts filling
        send_symbol(2'd1, 1'b1, 1'b0);
        send_symbol(2'd2, 1'b0, 1'b0);
        send_symbol(2'd3, 1'b1, 1'b0);
        send_symbol(2'd0, 1'b0, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b0);
        send_symbol(2'd2, 1'b0, 1'b1);
    endtask

    task automatic test_length_limits();
        // zero acts as one: every symbol completes a window
        write_motif_length(pwmsc_pkg::LEN_W'(0));
        send_symbol(2'd3, 1'b1, 1'b0);
        send_symbol(2'd0, 1'b0, 1'b1);
        // above the maximum acts as the maximum
        write_motif_length(pwmsc_pkg::LEN_W'(63));
        send_symbol(2'd0, 1'b1, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b1);
    endtask

    task automatic random_phase(input logic [pwmsc_pkg::LEN_W-1:0] cfg, input int n_items);
        int                             sent;
        int                             r;
        int                             len;
        int                             seq_len;
        bit                             same;
        logic [pwmsc_pkg::SYMBOL_W-1:0] s0;
        sent = 0;
        write_motif_length(cfg);
        len = window_len();
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_beat(pwmsc_pkg::KIND_WEIGHT, pwmsc_pkg::SYMBOL_W'($urandom),
                          pwmsc_pkg::POSITION_W'($urandom),
                          pwmsc_pkg::WEIGHT_W'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (r < 16) begin
                send_symbol(pwmsc_pkg::SYMBOL_W'($urandom), 1'($urandom_range(0, 3) == 0),
                            1'($urandom_range(0, 3) == 0));
                sent++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    seq_len = $urandom_range(1, len / 2 + 1);
                end else begin
                    seq_len = $urandom_range(len, len + 6);
                end
                // constant sequences drive the score toward its extremes
                same = ($urandom_range(0, 7) == 0);
                s0   = pwmsc_pkg::SYMBOL_W'($urandom);
                for (int k = 0; k < seq_len; k++) begin
                    send_symbol(same ? s0 : pwmsc_pkg::SYMBOL_W'($urandom),
                                k == 0 && $urandom_range(0, 7) != 0,
                                k == seq_len - 1);
                end
                sent += seq_len;
            end
        end
    endtask

    task automatic test_random_scan();
        random_phase(pwmsc_pkg::LEN_W'(1), 30);
        random_phase(pwmsc_pkg::LEN_W'(32), 90);
        calm = 1'b1;
        random_phase(pwmsc_pkg::LEN_W'(7), 60);
        calm = 1'b0;
        random_phase(pwmsc_pkg::LEN_W'(2), 30);
        random_phase(pwmsc_pkg::LEN_W'($urandom_range(33, 63)), 40);
        random_phase(pwmsc_pkg::LEN_W'($urandom_range(0, 63)), 90);
    endtask

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (score_q.size() == 0) begin
                $display("%0t: unexpected beat score=%0d eos=%0b too_short=%0b",
                         $time, window_score, end_of_sequence, too_short);
                errors++;
            end else begin
                head = score_q.pop_front();
                if (window_score !== head.score) begin
                    $display("%0t: window_score expected %0d actual %0d",
                             $time, head.score, window_score);
                    errors++;
                end
                if (end_of_sequence !== head.eos) begin
                    $display("%0t: end_of_sequence expected %0b actual %0b",
                             $time, head.eos, end_of_sequence);
                    errors++;
                end
                if (too_short !== head.short_seq) begin
                    $display("%0t: too_short expected %0b actual %0b",
                             $time, head.short_seq, too_short);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (running_sum[i]) begin
            running_sum[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_sequence_cases();
        test_length_limits();
        test_random_scan();
        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
